FILE: hw/rtl/owr_pkg.sv
package owr_pkg;

	// Ring geometry.
	localparam int DEPTH  = 16;
	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// Item field widths.
	localparam int HANDLE_W = 32;
	localparam int LEN_W    = 20;
	localparam int POS_W    = 24;
	localparam int TAG_W    = 4;

	// The running base never exceeds DEPTH entries of the largest length.
	localparam int BASE_W = LEN_W + SLOT_W;
	localparam int CMP_W  = ((BASE_W > POS_W) ? BASE_W : POS_W) + 1;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

	// Operation codes of an input item.
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_FIND = 1'b1;

	// Write request from the sequencer into the entry store.
	typedef struct packed {
		logic                en;
		logic [SLOT_W-1:0]   addr;
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0]    length;
	} owr_wr_req_t;

	// One stored entry as read back from the store.
	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0]    length;
	} owr_entry_t;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		next_slot = (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
	endfunction

	// Low four bits of a slot number, zero padded on a small ring.
	function automatic logic [TAG_W-1:0] slot_tag(input logic [SLOT_W-1:0] s);
		logic [SLOT_W+TAG_W-1:0] ext;
		ext      = {{TAG_W{1'b0}}, s};
		slot_tag = ext[TAG_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/owr_if.sv
interface owr_cmd_if import owr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                op;
	logic [HANDLE_W-1:0] entry_handle;
	logic [LEN_W-1:0]    entry_length;
	logic [POS_W-1:0]    char_position;

	modport source (output valid, op, entry_handle, entry_length, char_position, input ready);
	modport sink (input valid, op, entry_handle, entry_length, char_position, output ready);
endinterface

interface owr_res_if import owr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                found;
	logic [HANDLE_W-1:0] found_handle;
	logic [TAG_W-1:0]    found_slot;
	logic [LEN_W-1:0]    byte_within;

	modport source (output valid, found, found_handle, found_slot, byte_within, input ready);
	modport sink (input valid, found, found_handle, found_slot, byte_within, output ready);
endinterface

FILE: hw/rtl/owr_store.sv
module owr_store import owr_pkg::*; (
	input  logic              clk,
	input  owr_wr_req_t       wr,
	input  logic [SLOT_W-1:0] rd_addr,
	output owr_entry_t        rd_data
);

	owr_entry_t mem_q [DEPTH];
	owr_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= '{handle: wr.handle, length: wr.length};
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/owr_seq.sv
module owr_seq import owr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	owr_cmd_if.sink           cmd,
	owr_res_if.source         res,
	output owr_wr_req_t       wr,
	output logic [SLOT_W-1:0] rd_addr,
	input  owr_entry_t        rd_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PRIME = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]          state_q;
	logic [SLOT_W-1:0]   write_q;
	logic [SLOT_W-1:0]   read_q;
	logic                full_q;

	logic [POS_W-1:0]    pos_q;
	logic [BASE_W-1:0]   base_q;
	logic [SLOT_W-1:0]   fetch_q;
	logic [SLOT_W-1:0]   cur_q;
	logic [CNT_W-1:0]    remain_q;

	logic                hit_found_q;
	logic [HANDLE_W-1:0] hit_handle_q;
	logic [TAG_W-1:0]    hit_slot_q;
	logic [LEN_W-1:0]    hit_within_q;

	logic                out_valid_q;
	logic                out_found_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic [TAG_W-1:0]    out_slot_q;
	logic [LEN_W-1:0]    out_within_q;

	logic                cmd_fire;
	logic                out_load_c;
	logic [CNT_W-1:0]    count_c;
	logic [CMP_W-1:0]    sum_c;
	logic [CMP_W-1:0]    within_c;
	logic                hit_c;
	logic [SLOT_W-1:0]   read_next_c;
	logic [SLOT_W-1:0]   write_next_c;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;

	// The finished walk moves into the output register once that register is free.
	assign out_load_c = (state_q == ST_DONE) && (!out_valid_q || res.ready);

	assign wr.en     = cmd_fire && (cmd.op == OP_ADD);
	assign wr.addr   = write_q;
	assign wr.handle = cmd.entry_handle;
	assign wr.length = cmd.entry_length;

	assign rd_addr = fetch_q;

	// Number of valid entries, oldest at the read slot.
	always_comb begin
		if (full_q) begin
			count_c = CNT_W'(DEPTH);
		end else if (write_q >= read_q) begin
			count_c = CNT_W'(write_q) - CNT_W'(read_q);
		end else begin
			count_c = CNT_W'(write_q) + CNT_W'(DEPTH) - CNT_W'(read_q);
		end
	end

	assign write_next_c = next_slot(write_q);
	assign read_next_c  = full_q ? next_slot(read_q) : read_q;

	// The shared adder and comparator, used once per visited entry.
	assign sum_c    = CMP_W'(base_q) + CMP_W'(rd_data.length);
	assign hit_c    = CMP_W'(pos_q) < sum_c;
	assign within_c = CMP_W'(pos_q) - CMP_W'(base_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			write_q     <= '0;
			read_q      <= '0;
			full_q      <= 1'b0;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load_c) begin
				out_valid_q <= 1'b1;
			end else if (res.valid && res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire && (cmd.op == OP_ADD)) begin
						write_q <= write_next_c;
						read_q  <= read_next_c;
						full_q  <= (write_next_c == read_next_c);
					end else if (cmd_fire) begin
						remain_q <= count_c;
						state_q  <= (count_c == '0) ? ST_DONE : ST_PRIME;
					end
				end
				ST_PRIME: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (hit_c || (remain_q == CNT_W'(1))) begin
						state_q <= ST_DONE;
					end else begin
						remain_q <= remain_q - CNT_W'(1);
					end
				end
				ST_DONE: begin
					if (out_load_c) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk datapath and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire && (cmd.op == OP_FIND)) begin
					pos_q        <= cmd.char_position;
					base_q       <= '0;
					fetch_q      <= read_q;
					hit_found_q  <= 1'b0;
					hit_handle_q <= '0;
					hit_slot_q   <= '0;
					hit_within_q <= '0;
				end
			end
			ST_PRIME: begin
				cur_q   <= fetch_q;
				fetch_q <= next_slot(fetch_q);
			end
			ST_WALK: begin
				if (hit_c) begin
					hit_found_q  <= 1'b1;
					hit_handle_q <= rd_data.handle;
					hit_slot_q   <= slot_tag(cur_q);
					hit_within_q <= within_c[LEN_W-1:0];
				end else begin
					base_q  <= sum_c[BASE_W-1:0];
					cur_q   <= fetch_q;
					fetch_q <= next_slot(fetch_q);
				end
			end
			ST_DONE: begin
				if (out_load_c) begin
					out_found_q  <= hit_found_q;
					out_handle_q <= hit_handle_q;
					out_slot_q   <= hit_slot_q;
					out_within_q <= hit_within_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.valid        = out_valid_q;
	assign res.found        = out_found_q;
	assign res.found_handle = out_handle_q;
	assign res.found_slot   = out_slot_q;
	assign res.byte_within  = out_within_q;

endmodule

FILE: hw/rtl/overwrite_ring_with_offset_lookup.sv
// Overwrite-oldest ring of DEPTH entries, each a handle and a byte length, with
// a lookup that maps a character offset onto the entries concatenated oldest first.
// Items arrive on the cmd channel (valid/ready); an add item stores an entry and
// gives no result, a find item gives exactly one result on the res channel.
// An add is taken while the block is idle and leaves it idle, ready for more.
// A find visits the stored entries one per cycle through an adder and a
// comparator, reading the entry store ahead by one slot. It passes a set-up
// state, a walk state over the entries oldest first and a done state that loads
// the result register (an empty ring goes straight to done); cmd.ready stays low
// throughout, so a new item waits until the result is loaded. Sustained rate is
// one add per cycle while no find is in progress.
// The result sits in an output register; while the receiver stalls, the block
// still takes adds and starts the next find, which waits in its last state until
// the output register is free.
// Reset (arst_n low) empties the ring and drops any pending result; the entry
// store is not cleared, since only slots written since reset are ever visited.
module overwrite_ring_with_offset_lookup import owr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	owr_cmd_if.sink   cmd,
	owr_res_if.source res
);

	owr_wr_req_t       wr;
	logic [SLOT_W-1:0] rd_addr;
	owr_entry_t        rd_data;

	// Sequencer: ring pointers, the walk over the entries and the output register.
	owr_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.res     (res),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Entry store: one write port for adds, one registered read port for the walk.
	owr_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

FILE: hw/rtl/owr_checker.sv
module owr_checker import owr_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_ready,
	input logic                cmd_op,
	input logic                res_valid,
	input logic                res_ready,
	input logic                res_found,
	input logic [HANDLE_W-1:0] res_found_handle,
	input logic [TAG_W-1:0]    res_found_slot,
	input logic [LEN_W-1:0]    res_byte_within
);

	// A stalled result keeps its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_found)
			&& $stable(res_found_handle) && $stable(res_found_slot)
			&& $stable(res_byte_within))
		else $error("result item changed while stalled");

	// An add never produces a result item.
	a_add_silent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_op == OP_ADD) && !res_valid |=> !res_valid)
		else $error("result item appeared after an add");

	// A find occupies the block for at least the following cycle.
	a_find_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_op == OP_FIND) |=> !cmd_ready)
		else $error("block ready directly after accepting a find");

	// A miss reports all-zero fields.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_found |-> (res_found_handle == '0) && (res_found_slot == '0)
			&& (res_byte_within == '0))
		else $error("miss carries non-zero fields");

endmodule

bind overwrite_ring_with_offset_lookup owr_checker u_owr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.cmd_op           (cmd.op),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_found        (res.found),
	.res_found_handle (res.found_handle),
	.res_found_slot   (res.found_slot),
	.res_byte_within  (res.byte_within)
);
